@@ rtl/isolated_hit_interval_filter_unit_assert.svh @@
// Assertion macros shared by the checker of the isolated hit interval filter.
// No dependencies; include by bare file name.
`ifndef ISOLATED_HIT_INTERVAL_FILTER_UNIT_ASSERT_SVH
`define ISOLATED_HIT_INTERVAL_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset
`define IHIF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ihif check failed: same-cycle implication");

// Next-cycle implication, off during reset
`define IHIF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ihif check failed: next-cycle implication");

// Next-cycle implication that also holds across reset
`define IHIF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ihif check failed: next-cycle implication across reset");

`endif

@@ rtl/ihif_pkg.sv @@
// Package of the isolated hit interval filter: widths, defaults, codes, states.
// No dependencies.
`default_nettype none

package ihif_pkg;

    // Parameter defaults
    localparam int DEF_NUM_BINS = 256;
    localparam int DEF_MAX_HITS = 64;

    // Field widths
    localparam int POS_W       = 16;
    localparam int EXT_W       = 8;
    localparam int WCNT_W      = 9;
    localparam int CNT_W       = 7;
    localparam int HIT_INDEX_W = 6;
    localparam int HIT_ENTRY_W = POS_W + 2 * EXT_W;
    localparam int CLIP_W      = 18;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 1'b1;

    // Register reset values
    localparam logic [POS_W-1:0]  WINDOW_LOW_RST   = '0;
    localparam logic [WCNT_W-1:0] WINDOW_COUNT_RST = 9'd256;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_CLIP,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_CHK_FETCH,
        ST_CHK_CLIP,
        ST_CHK_RD,
        ST_CHK_TEST,
        ST_CHK_EMIT,
        ST_FLUSH
    } ihif_state_t;

endpackage

`default_nettype wire

@@ rtl/ihif_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ihif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds between reads
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ihif_clip.sv @@
// Shared range unit: clips a hit's bin interval to the coverage window.
// Depends on ihif_pkg.
`default_nettype none

module ihif_clip
    import ihif_pkg::*;
#(
    parameter int NUM_BINS = DEF_NUM_BINS
) (
    input  wire logic [HIT_ENTRY_W-1:0]      entry,     // {above, below, position}
    input  wire logic [POS_W-1:0]            win_low,
    input  wire logic [WCNT_W-1:0]           win_count,
    output logic                             nonempty,
    output logic      [$clog2(NUM_BINS)-1:0] lo,
    output logic      [$clog2(NUM_BINS)-1:0] hi
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam logic signed [CLIP_W-1:0] NBINS_S = CLIP_W'(NUM_BINS);

    logic signed [CLIP_W-1:0] pos_s, base_s, below_s, above_s;
    logic signed [CLIP_W-1:0] a_s, b_s, n_s, nm1_s, lo_s, hi_s, wcnt_s;

    // Relative interval, then clamp to [0, n-1]
    always_comb begin
        pos_s   = {{(CLIP_W-POS_W){entry[POS_W-1]}}, entry[POS_W-1:0]};
        base_s  = {{(CLIP_W-POS_W){win_low[POS_W-1]}}, win_low};
        below_s = {{(CLIP_W-EXT_W){1'b0}}, entry[POS_W+EXT_W-1:POS_W]};
        above_s = {{(CLIP_W-EXT_W){1'b0}}, entry[HIT_ENTRY_W-1:POS_W+EXT_W]};
        wcnt_s  = {{(CLIP_W-WCNT_W){1'b0}}, win_count};
        a_s     = pos_s - below_s - base_s;
        b_s     = pos_s + above_s - base_s;
        n_s     = (wcnt_s > NBINS_S) ? NBINS_S : wcnt_s;
        nm1_s   = n_s - CLIP_W'(1);
        lo_s    = (a_s < 0) ? '0 : a_s;
        hi_s    = (b_s > nm1_s) ? nm1_s : b_s;
    end

    assign nonempty = (lo_s <= hi_s);
    assign lo       = lo_s[BIN_W-1:0];
    assign hi       = hi_s[BIN_W-1:0];

endmodule

`default_nettype wire

@@ rtl/isolated_hit_interval_filter_unit.sv @@
// Top level of the isolated hit interval filter: sequencer, hit store, coverage store.
// Depends on ihif_pkg, ihif_ram, ihif_clip.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  tdata {above, below, position}, tlast = last hit
//   m_       out  m_tvalid/m_tready  tdata {above, below, position, index}, tuser, tlast
//   cfg_     in   cfg_wr_en          cfg_index, cfg_wdata (window_low, window_count)
//
// Each stored hit passes through the clip state, then a coverage read and an
// incremented write for every bin of its clipped interval.
// The last hit then scans every stored hit: fetch and clip, a read and a test per
// bin checked, an emit for a hit that is kept, then a closing fetch, the flush
// and a clearing pass over all NUM_BINS counters.
// Reset starts the same clearing pass; s_tready stays low during it.
// A stalled result beat holds the scan at its next emit or at the flush; the input
// waits meanwhile.
`default_nettype none

module isolated_hit_interval_filter_unit
    import ihif_pkg::*;
#(
    parameter int NUM_BINS = DEF_NUM_BINS,
    parameter int MAX_HITS = DEF_MAX_HITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // [15:0] hit_position, [23:16] extent_below, [31:24] extent_above
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [5:0] hit_index, [21:6] kept_position, [29:22] kept_below,
    // [37:30] kept_above, [39:38] zero
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // [0] none_accepted
    output logic                        m_tuser,
    output logic                        m_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int HI_W  = $clog2(MAX_HITS);
    localparam int HC_W  = $clog2(MAX_HITS + 1);
    localparam int PAD_W = OUT_TDATA_W - HIT_INDEX_W - HIT_ENTRY_W;

    ihif_state_t state_reg, state_next;

    logic [POS_W-1:0]       window_low_reg;
    logic [WCNT_W-1:0]      window_count_reg;

    logic [HIT_ENTRY_W-1:0] hit_entry_reg, hit_entry_next;
    logic                   last_reg, last_next;
    logic [HC_W-1:0]        hits_held_reg, hits_held_next;
    logic [HC_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [BIN_W-1:0]       bin_reg, bin_next;
    logic [BIN_W-1:0]       bin_hi_reg, bin_hi_next;
    logic [BIN_W-1:0]       clr_idx_reg, clr_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [HIT_ENTRY_W-1:0] pend_entry_reg, pend_entry_next;
    logic [HI_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HIT_ENTRY_W-1:0] out_entry_reg, out_entry_next;
    logic [HIT_INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic                   out_none_reg, out_none_next;
    logic                   out_final_reg, out_final_next;

    logic                   s_accept, store_full, out_free;
    logic                   hit_we, hit_re;
    logic [HIT_ENTRY_W-1:0] hit_rdata;
    logic                   cnt_we, cnt_re;
    logic [BIN_W-1:0]       cnt_waddr;
    logic [CNT_W-1:0]       cnt_wdata, cnt_rdata;
    logic [HIT_ENTRY_W-1:0] clip_entry;
    logic                   clip_nonempty;
    logic [BIN_W-1:0]       clip_lo, clip_hi;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign store_full = (hits_held_reg == HC_W'(MAX_HITS));
    assign out_free   = !out_valid_reg || m_tready;
    assign hit_we     = s_accept && !store_full;

    // Hit store, written at the beat that carries the hit unless the store is full
    ihif_ram #(
        .WIDTH (HIT_ENTRY_W),
        .DEPTH (MAX_HITS)
    ) u_hit_ram (
        .clk   (aclk),
        .we    (hit_we),
        .waddr (hits_held_reg[HI_W-1:0]),
        .wdata (s_tdata[HIT_ENTRY_W-1:0]),
        .re    (hit_re),
        .raddr (scan_idx_reg[HI_W-1:0]),
        .rdata (hit_rdata)
    );

    // Coverage counters
    ihif_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_cnt_ram (
        .clk   (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (bin_reg),
        .rdata (cnt_rdata)
    );

    // Range unit, shared by the count and check passes
    assign clip_entry = (state_reg == ST_ADD_CLIP) ? hit_entry_reg : hit_rdata;

    ihif_clip #(
        .NUM_BINS (NUM_BINS)
    ) u_clip (
        .entry     (clip_entry),
        .win_low   (window_low_reg),
        .win_count (window_count_reg),
        .nonempty  (clip_nonempty),
        .lo        (clip_lo),
        .hi        (clip_hi)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_low_reg   <= WINDOW_LOW_RST;
            window_count_reg <= WINDOW_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WINDOW_LOW:   window_low_reg   <= cfg_wdata;
                CFG_WINDOW_COUNT: window_count_reg <= cfg_wdata[WCNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer: next state, datapath updates, store controls
    always_comb begin
        state_next      = state_reg;
        hit_entry_next  = hit_entry_reg;
        last_next       = last_reg;
        hits_held_next  = hits_held_reg;
        scan_idx_next   = scan_idx_reg;
        bin_next        = bin_reg;
        bin_hi_next     = bin_hi_reg;
        clr_idx_next    = clr_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_entry_next = pend_entry_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_entry_next  = out_entry_reg;
        out_idx_next    = out_idx_reg;
        out_none_next   = out_none_reg;
        out_final_next  = out_final_reg;
        hit_re          = 1'b0;
        cnt_re          = 1'b0;
        cnt_we          = 1'b0;
        cnt_waddr       = bin_reg;
        cnt_wdata       = cnt_rdata + 1'b1;

        unique case (state_reg)
            // Sweep the counters to zero
            ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_idx_reg;
                cnt_wdata = '0;
                if (clr_idx_reg == BIN_W'(NUM_BINS - 1)) begin
                    clr_idx_next = '0;
                    state_next   = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            // Take a hit; drop it from counting when the store is full
            ST_IDLE: begin
                if (s_accept) begin
                    hit_entry_next = s_tdata[HIT_ENTRY_W-1:0];
                    last_next      = s_tlast;
                    if (!store_full) begin
                        hits_held_next = hits_held_reg + 1'b1;
                        state_next     = ST_ADD_CLIP;
                    end else if (s_tlast) begin
                        scan_idx_next = '0;
                        state_next    = ST_CHK_FETCH;
                    end
                end
            end

            ST_ADD_CLIP: begin
                bin_next    = clip_lo;
                bin_hi_next = clip_hi;
                if (clip_nonempty) begin
                    state_next = ST_ADD_RD;
                end else if (last_reg) begin
                    scan_idx_next = '0;
                    state_next    = ST_CHK_FETCH;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_ADD_RD: begin
                cnt_re     = 1'b1;
                state_next = ST_ADD_WR;
            end

            // Write back the bumped count, advance to the next bin or finish the hit
            ST_ADD_WR: begin
                cnt_we = 1'b1;
                if (bin_reg != bin_hi_reg) begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = ST_ADD_RD;
                end else if (last_reg) begin
                    scan_idx_next = '0;
                    state_next    = ST_CHK_FETCH;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_CHK_FETCH: begin
                if (scan_idx_reg == hits_held_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    hit_re     = 1'b1;
                    state_next = ST_CHK_CLIP;
                end
            end

            ST_CHK_CLIP: begin
                bin_next    = clip_lo;
                bin_hi_next = clip_hi;
                state_next  = clip_nonempty ? ST_CHK_RD : ST_CHK_EMIT;
            end

            ST_CHK_RD: begin
                cnt_re     = 1'b1;
                state_next = ST_CHK_TEST;
            end

            // Reject on the first shared bin
            ST_CHK_TEST: begin
                if (cnt_rdata != CNT_W'(1)) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    state_next    = ST_CHK_FETCH;
                end else if (bin_reg == bin_hi_reg) begin
                    state_next = ST_CHK_EMIT;
                end else begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = ST_CHK_RD;
                end
            end

            // Hold the newest accepted hit back until the next one shows
            // whether it is the final result
            ST_CHK_EMIT: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_entry_next = pend_entry_reg;
                        out_idx_next   = HIT_INDEX_W'(pend_idx_reg);
                        out_none_next  = 1'b0;
                        out_final_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_entry_next = hit_rdata;
                    pend_idx_next   = scan_idx_reg[HI_W-1:0];
                    scan_idx_next   = scan_idx_reg + 1'b1;
                    state_next      = ST_CHK_FETCH;
                end
            end

            // Send the final beat, or the empty marker, then clear
            ST_FLUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_final_next = 1'b1;
                    if (pend_valid_reg) begin
                        out_entry_next = pend_entry_reg;
                        out_idx_next   = HIT_INDEX_W'(pend_idx_reg);
                        out_none_next  = 1'b0;
                    end else begin
                        out_entry_next = '0;
                        out_idx_next   = '0;
                        out_none_next  = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    hits_held_next  = '0;
                    clr_idx_next    = '0;
                    state_next      = ST_CLEAR;
                end
            end

            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            hits_held_reg  <= '0;
            scan_idx_reg   <= '0;
            clr_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hits_held_reg  <= hits_held_next;
            scan_idx_reg   <= scan_idx_next;
            clr_idx_reg    <= clr_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        hit_entry_reg  <= hit_entry_next;
        last_reg       <= last_next;
        bin_reg        <= bin_next;
        bin_hi_reg     <= bin_hi_next;
        pend_entry_reg <= pend_entry_next;
        pend_idx_reg   <= pend_idx_next;
        out_entry_reg  <= out_entry_next;
        out_idx_reg    <= out_idx_next;
        out_none_reg   <= out_none_next;
        out_final_reg  <= out_final_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_entry_reg, out_idx_reg};
    assign m_tuser  = out_none_reg;
    assign m_tlast  = out_final_reg;

endmodule

`default_nettype wire

@@ rtl/ihif_checker.sv @@
// Port-level checks of the isolated hit interval filter, bound to the top level.
// Depends on ihif_pkg and isolated_hit_interval_filter_unit_assert.svh.
`default_nettype none
`include "isolated_hit_interval_filter_unit_assert.svh"

module ihif_checker
    import ihif_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tlast,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic                   m_tuser,
    input wire logic                   m_tlast,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready
);

    // A stalled result beat holds
    `IHIF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // The last hit of an event always starts work: ready drops after its beat
    `IHIF_ASSERT_NEXT(a_last_busy, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)

    // The empty marker is the final beat and carries no hit
    `IHIF_ASSERT_IMP(a_marker, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata == '0))

    // Reset starts the clearing pass with no beat on either side
    `IHIF_ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid && !s_tready)

endmodule

bind isolated_hit_interval_filter_unit ihif_checker u_ihif_checker (.*);

`default_nettype wire
